// File: hdl/rbc_pkg.sv
// Shared types, constants and helpers of the region brightness checker.
`default_nettype none
package rbc_pkg;

  localparam int PIX_W             = 8;
  localparam int WIN_W             = 10;
  localparam int MODE_W            = 3;
  localparam int LIM_W             = 16;
  localparam int RUN_W             = 16;
  localparam int MAX_REGION_PIXELS = 65536;
  localparam int CNT_W             = $clog2(MAX_REGION_PIXELS + 1);
  localparam int SUM_W             = $clog2(MAX_REGION_PIXELS * 255 + 1) + 1;
  localparam int QUO_BIT_W         = $clog2(PIX_W);
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int Q_DEPTH           = 2;
  localparam int QPTR_W            = $clog2(Q_DEPTH);
  localparam int QCNT_W            = $clog2(Q_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_AVG_IN  = 3'd0,
    MODE_ALL_IN  = 3'd1,
    MODE_ONE_IN  = 3'd2,
    MODE_AVG_OUT = 3'd3,
    MODE_ALL_OUT = 3'd4,
    MODE_ONE_OUT = 3'd5
  } check_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW   = 2'd0,
    REG_WINDOW_HIGH  = 2'd1,
    REG_CHECK_MODE   = 2'd2,
    REG_REPEAT_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic signed [WIN_W-1:0] window_low;
    logic signed [WIN_W-1:0] window_high;
    logic [MODE_W-1:0]       check_mode;
    logic [LIM_W-1:0]        repeat_limit;
  } cfg_t;

  // One finished region, handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic              decided;
    logic [PIX_W-1:0]  captured;
    logic [MODE_W-1:0] mode;
  } region_t;

  typedef struct packed {
    logic             verdict_ng;
    logic             raw_fail;
    logic [PIX_W-1:0] decisive_value;
    logic [RUN_W-1:0] miss_count;
  } result_t;

  // Window test on an unsigned brightness value; an empty window holds nothing.
  function automatic logic in_window(logic [PIX_W-1:0] v,
                                     logic signed [WIN_W-1:0] lo,
                                     logic signed [WIN_W-1:0] hi);
    logic signed [WIN_W:0] v_s;
    logic signed [WIN_W:0] lo_s;
    logic signed [WIN_W:0] hi_s;
    v_s  = $signed({{(WIN_W + 1 - PIX_W){1'b0}}, v});
    lo_s = {lo[WIN_W-1], lo};
    hi_s = {hi[WIN_W-1], hi};
    return (lo_s <= v_s) && (v_s <= hi_s);
  endfunction

endpackage
`default_nettype wire

// File: hdl/rbc_pix_if.sv
// Pixel stream channel: valid/ready handshake with one pixel per transfer.
`default_nettype none
interface rbc_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rbc_pkg::PIX_W-1:0]  pixel_value;
  logic                       last_pixel;

  modport source (output valid, output pixel_value, output last_pixel, input ready);
  modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface
`default_nettype wire

// File: hdl/rbc_res_if.sv
// Result channel: valid/ready handshake with one region verdict per transfer.
`default_nettype none
interface rbc_res_if;
  logic                       valid;
  logic                       ready;
  logic                       verdict_ng;
  logic                       raw_fail;
  logic [rbc_pkg::PIX_W-1:0]  decisive_value;
  logic [rbc_pkg::RUN_W-1:0]  miss_count;

  modport source (output valid, output verdict_ng, output raw_fail,
                  output decisive_value, output miss_count, input ready);
  modport sink   (input valid, input verdict_ng, input raw_fail,
                  input decisive_value, input miss_count, output ready);
endinterface
`default_nettype wire

// File: hdl/rbc_front.sv
// Front end: accumulates pixels of a region and tests each against the window.
`default_nettype none
module rbc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rbc_pkg::cfg_t    cfg_i,
  rbc_pix_if.sink               pix_i,
  input  wire logic             q_full_i,
  output      logic             q_push_o,
  output      rbc_pkg::region_t q_data_o
);

  logic [rbc_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [rbc_pkg::CNT_W-1:0] count_q, count_d;
  logic                      decided_q, decided_d;
  logic [rbc_pkg::PIX_W-1:0] captured_q, captured_d;
  logic                      accept;
  logic                      counting;
  logic                      in_win;
  logic                      decides;

  assign pix_i.ready = !q_full_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign counting    = count_q < rbc_pkg::CNT_W'(rbc_pkg::MAX_REGION_PIXELS);
  assign in_win      = rbc_pkg::in_window(pix_i.pixel_value, cfg_i.window_low,
                                          cfg_i.window_high);

  always_comb begin
    unique case (cfg_i.check_mode)
      rbc_pkg::MODE_ALL_IN, rbc_pkg::MODE_ONE_OUT: decides = !in_win;
      rbc_pkg::MODE_ONE_IN, rbc_pkg::MODE_ALL_OUT: decides = in_win;
      default:                                     decides = 1'b0;
    endcase
  end

  always_comb begin
    sum_d      = sum_q;
    count_d    = count_q;
    decided_d  = decided_q;
    captured_d = captured_q;
    // pixels past the region limit are dropped, but a flagged one still closes it
    if (counting) begin
      sum_d   = sum_q + rbc_pkg::SUM_W'(pix_i.pixel_value);
      count_d = count_q + rbc_pkg::CNT_W'(1);
      if (decides && !decided_q) begin
        decided_d  = 1'b1;
        captured_d = pix_i.pixel_value;
      end
    end
  end

  assign q_push_o          = accept && pix_i.last_pixel;
  assign q_data_o.sum      = sum_d;
  assign q_data_o.count    = count_d;
  assign q_data_o.decided  = decided_d;
  assign q_data_o.captured = captured_d;
  assign q_data_o.mode     = cfg_i.check_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      decided_q  <= 1'b0;
      captured_q <= '0;
    end else if (accept) begin
      captured_q <= captured_d;
      if (pix_i.last_pixel) begin
        sum_q     <= '0;
        count_q   <= '0;
        decided_q <= 1'b0;
      end else begin
        sum_q     <= sum_d;
        count_q   <= count_d;
        decided_q <= decided_d;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/rbc_queue.sv
// Short queue of finished regions between the front end and the back end.
`default_nettype none
module rbc_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rbc_pkg::region_t push_data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      rbc_pkg::region_t pop_data_o,
  output      logic             empty_o
);

  rbc_pkg::region_t             entry_q [rbc_pkg::Q_DEPTH];
  logic [rbc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rbc_pkg::QCNT_W-1:0]   fill_q;
  logic                         do_push;
  logic                         do_pop;

  assign full_o     = fill_q == rbc_pkg::QCNT_W'(rbc_pkg::Q_DEPTH);
  assign empty_o    = fill_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  function automatic logic [rbc_pkg::QPTR_W-1:0] next_ptr(logic [rbc_pkg::QPTR_W-1:0] p);
    return (p == rbc_pkg::QPTR_W'(rbc_pkg::Q_DEPTH - 1)) ? '0 : p + rbc_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop)      fill_q <= fill_q + rbc_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) fill_q <= fill_q - rbc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// File: hdl/rbc_back.sv
// Back end: divides out the region average, applies the mode and repeat filter.
`default_nettype none
module rbc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rbc_pkg::cfg_t    cfg_i,
  input  wire logic             q_empty_i,
  input  wire rbc_pkg::region_t q_data_i,
  output      logic             q_pop_o,
  rbc_res_if.source             res_o
);

  rbc_pkg::back_state_e           state_q, state_d;
  rbc_pkg::region_t               rec_q;
  logic [rbc_pkg::SUM_W-1:0]      rem_q;
  logic [rbc_pkg::PIX_W-1:0]      quo_q;
  logic [rbc_pkg::QUO_BIT_W-1:0]  bit_q;
  logic [rbc_pkg::RUN_W-1:0]      run_q, run_d;
  rbc_pkg::result_t               res_q, res_d;
  logic                           res_vld_q;
  logic                           load_rec;
  logic                           div_step;
  logic                           load_res;
  logic                           res_free;
  logic [rbc_pkg::SUM_W-1:0]      trial;
  logic                           take;
  logic [rbc_pkg::PIX_W-1:0]      avg;
  logic                           fail;
  logic                           reserved;
  logic [rbc_pkg::PIX_W-1:0]      decisive;
  logic [rbc_pkg::PIX_W-1:0]      pick;

  assign res_free = !res_vld_q || res_o.ready;

  // restoring division, one quotient bit per cycle; the average fits in a pixel
  assign trial = rbc_pkg::SUM_W'(rec_q.count) << bit_q;
  assign take  = rem_q >= trial;

  always_comb begin
    state_d  = state_q;
    load_rec = 1'b0;
    div_step = 1'b0;
    load_res = 1'b0;
    unique case (state_q)
      rbc_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          load_rec = 1'b1;
          state_d  = rbc_pkg::BK_DIV;
        end
      end
      rbc_pkg::BK_DIV: begin
        div_step = 1'b1;
        if (bit_q == '0) state_d = rbc_pkg::BK_DONE;
      end
      rbc_pkg::BK_DONE: begin
        if (res_free) begin
          load_res = 1'b1;
          state_d  = rbc_pkg::BK_IDLE;
        end
      end
      default: state_d = rbc_pkg::BK_IDLE;
    endcase
  end

  assign q_pop_o = load_rec;

  assign avg  = (rec_q.count == '0) ? '0 : quo_q;
  assign pick = rec_q.decided ? rec_q.captured : '0;

  always_comb begin
    fail     = 1'b0;
    reserved = 1'b0;
    decisive = '0;
    unique case (rec_q.mode)
      rbc_pkg::MODE_AVG_IN: begin
        decisive = avg;
        fail     = !rbc_pkg::in_window(avg, cfg_i.window_low, cfg_i.window_high);
      end
      rbc_pkg::MODE_AVG_OUT: begin
        decisive = avg;
        fail     = rbc_pkg::in_window(avg, cfg_i.window_low, cfg_i.window_high);
      end
      rbc_pkg::MODE_ALL_IN, rbc_pkg::MODE_ALL_OUT: begin
        decisive = pick;
        fail     = rec_q.decided;
      end
      rbc_pkg::MODE_ONE_IN, rbc_pkg::MODE_ONE_OUT: begin
        decisive = pick;
        fail     = !rec_q.decided;
      end
      default: reserved = 1'b1;
    endcase
  end

  always_comb begin
    run_d = run_q;
    if (!reserved) begin
      if (!fail)                                 run_d = '0;
      else if (run_q != {rbc_pkg::RUN_W{1'b1}}) run_d = run_q + rbc_pkg::RUN_W'(1);
    end
    res_d.verdict_ng     = !reserved && fail && (run_d >= cfg_i.repeat_limit);
    res_d.raw_fail       = fail;
    res_d.decisive_value = decisive;
    res_d.miss_count     = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rbc_pkg::BK_IDLE;
      run_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res) begin
        run_q     <= run_d;
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rec) begin
      rec_q <= q_data_i;
      rem_q <= q_data_i.sum;
      quo_q <= '0;
      bit_q <= rbc_pkg::QUO_BIT_W'(rbc_pkg::PIX_W - 1);
    end
    if (div_step) begin
      if (take) begin
        rem_q        <= rem_q - trial;
        quo_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - rbc_pkg::QUO_BIT_W'(1);
    end
    if (load_res) res_q <= res_d;
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.verdict_ng     = res_q.verdict_ng;
  assign res_o.raw_fail       = res_q.raw_fail;
  assign res_o.decisive_value = res_q.decisive_value;
  assign res_o.miss_count     = res_q.miss_count;

endmodule
`default_nettype wire

// File: hdl/region_brightness_check.sv
// Top level of the region brightness checker: configuration registers and wiring.
// Pixels are taken one per clock for as long as the region queue has room; the
// front end sums and window-tests each pixel as it arrives. When the flagged last
// pixel is taken, the region is queued and the back end loads it, runs the
// bit-serial average divider one quotient bit at a time, then evaluates into the
// output register once that register is free; the back end takes a new region
// only after finishing the last one. The two-entry region queue absorbs bursts
// of short regions; the pixel input stalls only while it is full. Write the
// configuration registers only while no region is in flight.
`default_nettype none
module region_brightness_check (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rbc_pix_if.sink                               pix_i,
  rbc_res_if.source                             res_o
);

  rbc_pkg::cfg_t    cfg_q;
  rbc_pkg::region_t push_data;
  rbc_pkg::region_t pop_data;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low   <= rbc_pkg::WIN_W'(0);
      cfg_q.window_high  <= rbc_pkg::WIN_W'(256);
      cfg_q.check_mode   <= rbc_pkg::MODE_AVG_IN;
      cfg_q.repeat_limit <= rbc_pkg::LIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbc_pkg::REG_WINDOW_LOW:   cfg_q.window_low   <= cfg_data_i[rbc_pkg::WIN_W-1:0];
        rbc_pkg::REG_WINDOW_HIGH:  cfg_q.window_high  <= cfg_data_i[rbc_pkg::WIN_W-1:0];
        rbc_pkg::REG_CHECK_MODE:   cfg_q.check_mode   <= cfg_data_i[rbc_pkg::MODE_W-1:0];
        rbc_pkg::REG_REPEAT_LIMIT: cfg_q.repeat_limit <= cfg_data_i[rbc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  rbc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .pix_i    (pix_i),
    .q_full_i (q_full),
    .q_push_o (push),
    .q_data_o (push_data)
  );

  rbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  rbc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

// File: test/region_brightness_check_test.sv
// Self-checking testbench of region_brightness_check: directed table, bulk cases, random regions.
`timescale 1ns / 100ps
module region_brightness_check_test;
  import rbc_pkg::*;

  localparam int          CYCLE_LIMIT   = 4_000_000;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          MAX_REPORTS   = 10;
  localparam int          RANDOM_ITEMS  = 283;
  localparam int          SAT_REGIONS   = 65537;
  localparam logic [2:0]  MODE_RSVD_LO  = 3'd6;
  localparam logic [2:0]  MODE_RSVD_HI  = 3'd7;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [15:0]       data;
    logic [PIX_W-1:0]  px;
    logic              last;
    logic              known;
    result_t           verdict;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rbc_pix_if pix ();
  rbc_res_if res ();

  region_brightness_check dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  int          cfg_lo       = 0;
  int          cfg_hi       = 256;
  logic [2:0]  cfg_mode     = MODE_AVG_IN;
  logic [15:0] cfg_limit    = 16'd1;
  logic [63:0] acc_sum      = '0;
  int unsigned acc_count    = 0;
  bit          acc_decided  = 1'b0;
  logic [7:0]  acc_captured = '0;
  logic [15:0] miss_run     = '0;

  result_t pending_verdicts[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      mismatches    = 0;
  int      cycle_cnt     = 0;

  dir_row_t directed_rows [0:37] = '{
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd255, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd255, 16'd0}},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd0,   1'b1, 1'b1, '{1'b0, 1'b0, 8'd0,   16'd0}},
    '{ROW_CFG, REG_WINDOW_LOW,   16'h01FF,  8'd0,   1'b0, 1'b0, '0},
    '{ROW_CFG, REG_WINDOW_HIGH,  16'hFF00,  8'd0,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd128, 1'b1, 1'b1, '{1'b1, 1'b1, 8'd128, 16'd1}},
    '{ROW_CFG, REG_REPEAT_LIMIT, 16'd0,     8'd0,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd7,   1'b1, 1'b1, '{1'b1, 1'b1, 8'd7,   16'd2}},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_RSVD_LO), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd200, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0,   16'd2}},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_RSVD_HI), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd1,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd2,   1'b1, 1'b1, '{1'b0, 1'b0, 8'd0,   16'd2}},
    '{ROW_CFG, REG_WINDOW_LOW,   16'hFF00,  8'd0,   1'b0, 1'b0, '0},
    '{ROW_CFG, REG_WINDOW_HIGH,  16'h01FF,  8'd0,   1'b0, 1'b0, '0},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_ALL_IN), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_REPEAT_LIMIT, 16'd3,     8'd0,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd0,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd255, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd100, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0,   16'd0}},
    '{ROW_CFG, REG_WINDOW_LOW,   16'd10,    8'd0,   1'b0, 1'b0, '0},
    '{ROW_CFG, REG_WINDOW_HIGH,  16'd20,    8'd0,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd15,  1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd5,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd30,  1'b1, 1'b1, '{1'b0, 1'b1, 8'd5,   16'd1}},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_ONE_IN), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd0,   1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd255, 1'b1, 1'b1, '{1'b0, 1'b1, 8'd0,   16'd2}},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_ALL_OUT), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd20,  1'b1, 1'b1, '{1'b1, 1'b1, 8'd20,  16'd3}},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_ONE_OUT), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd10,  1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd21,  1'b1, 1'b1, '{1'b0, 1'b0, 8'd21,  16'd0}},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_AVG_OUT), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd10,  1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd21,  1'b1, 1'b0, '0},
    '{ROW_CFG, REG_CHECK_MODE,   16'(MODE_AVG_IN), 8'd0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd254, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_WINDOW_LOW,   16'd0,     8'd255, 1'b1, 1'b0, '0}
  };

  function automatic bit window_holds(input int v);
    return cfg_lo <= v && v <= cfg_hi;
  endfunction

  // Advance the region state by one pixel; return 1 with the verdict on the last one.
  function automatic bit judge_pixel(input logic [7:0] px, input bit last, output result_t r);
    logic [7:0] avg;
    logic [7:0] value;
    bit         fail;
    bit         reserved;
    bit         px_in_win;
    bit         decides;
    avg      = '0;
    value    = '0;
    fail     = 1'b0;
    reserved = 1'b0;
    decides  = 1'b0;
    r        = '0;
    if (acc_count < MAX_REGION_PIXELS) begin
      px_in_win  = window_holds(int'(px));
      acc_sum   += px;
      acc_count += 1;
      if (cfg_mode == MODE_ALL_IN || cfg_mode == MODE_ONE_OUT) begin
        decides = !px_in_win;
      end else if (cfg_mode == MODE_ONE_IN || cfg_mode == MODE_ALL_OUT) begin
        decides = px_in_win;
      end
      if (decides && !acc_decided) begin
        acc_decided  = 1'b1;
        acc_captured = px;
      end
    end
    if (!last) return 1'b0;
    if (acc_count != 0) avg = 8'(acc_sum / acc_count);
    case (cfg_mode)
      MODE_AVG_IN: begin
        value = avg;
        fail  = !window_holds(int'(avg));
      end
      MODE_AVG_OUT: begin
        value = avg;
        fail  = window_holds(int'(avg));
      end
      MODE_ALL_IN, MODE_ALL_OUT: begin
        fail  = acc_decided;
        value = acc_decided ? acc_captured : 8'd0;
      end
      MODE_ONE_IN, MODE_ONE_OUT: begin
        fail  = !acc_decided;
        value = acc_decided ? acc_captured : 8'd0;
      end
      default: reserved = 1'b1;
    endcase
    if (!reserved) begin
      if (fail) begin
        if (miss_run != 16'hFFFF) miss_run++;
        r.verdict_ng = (miss_run >= cfg_limit);
      end else begin
        miss_run = '0;
      end
    end
    r.raw_fail       = fail;
    r.decisive_value = value;
    r.miss_count     = miss_run;
    acc_sum     = '0;
    acc_count   = 0;
    acc_decided = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_pixel(input logic [7:0] px, input bit last, input bit known,
                            input result_t typed);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= px;
    pix.last_pixel  <= last;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    if (judge_pixel(px, last, predicted)) begin
      pending_verdicts.push_back(known ? typed : predicted);
    end
  endtask

  // Wait until the block is idle, then write one register.
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    pix.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WINDOW_LOW:   cfg_lo = int'($signed(data[WIN_W-1:0]));
      REG_WINDOW_HIGH:  cfg_hi = int'($signed(data[WIN_W-1:0]));
      REG_CHECK_MODE:   cfg_mode = data[MODE_W-1:0];
      REG_REPEAT_LIMIT: cfg_limit = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_random(input int n_items);
    int         sent;
    int         n_regions;
    int         len;
    int         lo;
    int         hi;
    int         v;
    logic [2:0] mode;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            lo = int'($urandom_range(0, 767)) - 256;
            hi = int'($urandom_range(0, 767)) - 256;
          end
          1: begin
            lo = $urandom_range(0, 1) ? -256 : 0;
            hi = $urandom_range(0, 1) ? 511 : 255;
          end
          default: begin
            lo = int'($urandom_range(0, 220)) - 10;
            hi = lo + int'($urandom_range(0, 90));
          end
        endcase
        if ($urandom_range(0, 9) == 0) mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
        else mode = 3'($urandom_range(MODE_AVG_IN, MODE_ONE_OUT));
        if ($urandom_range(0, 1)) write_reg(REG_WINDOW_LOW, 16'(lo));
        if ($urandom_range(0, 1)) write_reg(REG_WINDOW_HIGH, 16'(hi));
        if ($urandom_range(0, 2) != 0) write_reg(REG_CHECK_MODE, 16'(mode));
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 9) == 0) write_reg(REG_REPEAT_LIMIT, 16'($urandom_range(0, 65535)));
          else write_reg(REG_REPEAT_LIMIT, 16'($urandom_range(0, 4)));
        end
      end
      n_regions = $urandom_range(1, 6);
      repeat (n_regions) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          // Aim near the window edges often so both sides of each bound get hit.
          case ($urandom_range(0, 5))
            0: v = cfg_lo + int'($urandom_range(0, 4)) - 2;
            1: v = cfg_hi + int'($urandom_range(0, 4)) - 2;
            2: v = $urandom_range(0, 1) ? 255 : 0;
            default: v = $urandom_range(0, 255);
          endcase
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          send_pixel(8'(v), i == len - 1, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t seen;
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      seen = '{res.verdict_ng, res.raw_fail, res.decisive_value, res.miss_count};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: ng=%0d raw=%0d value=%0d misses=%0d",
                   seen.verdict_ng, seen.raw_fail, seen.decisive_value, seen.miss_count);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (seen.verdict_ng !== want.verdict_ng || seen.raw_fail !== want.raw_fail ||
            seen.decisive_value !== want.decisive_value ||
            seen.miss_count !== want.miss_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected ng=%0d raw=%0d value=%0d misses=%0d, got ng=%0d raw=%0d value=%0d misses=%0d",
                     want.verdict_ng, want.raw_fail, want.decisive_value, want.miss_count,
                     seen.verdict_ng, seen.raw_fail, seen.decisive_value, seen.miss_count);
          end
        end
      end
    end
    res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("region_brightness_check_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    pix.last_pixel  = 1'b0;
    res.ready       = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_WINDOW_LOW;
    cfg_data_i      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 69;
    for (int i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.data);
      else send_pixel(row.px, row.last, row.known, row.verdict);
    end
    run_random(RANDOM_ITEMS);

    send_idle_pct = 69;
    recv_idle_pct = 22;
    run_random(RANDOM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Overlong region: pixels past the limit, two of them outside the window, must be ignored.
    write_reg(REG_WINDOW_LOW, 16'd0);
    write_reg(REG_WINDOW_HIGH, 16'd200);
    write_reg(REG_CHECK_MODE, 16'(MODE_ALL_IN));
    write_reg(REG_REPEAT_LIMIT, 16'd1);
    repeat (MAX_REGION_PIXELS) send_pixel(8'($urandom_range(0, 200)), 1'b0, 1'b0, '0);
    send_pixel(8'd255, 1'b0, 1'b0, '0);
    send_pixel(8'd0, 1'b0, 1'b0, '0);
    send_pixel(8'd230, 1'b1, 1'b0, '0);

    // Empty window: every region fails, so the miss count climbs to saturation.
    write_reg(REG_WINDOW_LOW, 16'd1);
    write_reg(REG_WINDOW_HIGH, 16'd0);
    write_reg(REG_CHECK_MODE, 16'(MODE_AVG_IN));
    write_reg(REG_REPEAT_LIMIT, 16'hFFFF);
    repeat (SAT_REGIONS) send_pixel(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    run_random(RANDOM_ITEMS);

    pix.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("region_brightness_check_test OK");
    end else begin
      $display("region_brightness_check_test NOT OK");
    end
    $finish;
  end

endmodule

// File: region_brightness_check.f
hdl/rbc_pkg.sv
hdl/rbc_pix_if.sv
hdl/rbc_res_if.sv
hdl/rbc_front.sv
hdl/rbc_queue.sv
hdl/rbc_back.sv
hdl/region_brightness_check.sv
test/region_brightness_check_test.sv
